// ===== hdl/block_run_extent_coalescer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block run extent coalescer
// Clocked on clk, and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RUN_EXTENT_COALESCER_ASSERT_SVH
`define BLOCK_RUN_EXTENT_COALESCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BREC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/brec_pkg.sv =====
// ----------------------------------------------------------------------------
// brec_pkg
// Types and constants shared by the block run extent coalescer and its
// channel interfaces.
// ----------------------------------------------------------------------------
package brec_pkg;

  localparam int BLK_W   = 48;
  localparam int BYTE_W  = 64;
  localparam int SHIFT_W = 5;

  localparam logic [BLK_W-1:0] BLK_ONES = {BLK_W{1'b1}};

  // Sector shift limits and reset value.
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

  // Reserved byte ranges: the first megabyte and the two mirror areas.
  localparam logic [BYTE_W-1:0] RES0_END   = 64'h0000_0000_0010_0000;
  localparam logic [BYTE_W-1:0] RES1_START = 64'h0000_0000_0400_0000;
  localparam logic [BYTE_W-1:0] RES1_END   = 64'h0000_0000_0401_0000;
  localparam logic [BYTE_W-1:0] RES2_START = 64'h0000_0040_0000_0000;
  localparam logic [BYTE_W-1:0] RES2_END   = 64'h0000_0040_0001_0000;

  typedef struct packed {
    logic [BLK_W-1:0]  disk_blk;
    logic [BLK_W-1:0]  file_blk;
    logic [BYTE_W-1:0] group_end_byte;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] ext_file_blk;
    logic [BLK_W-1:0] ext_disk_blk;
    logic [BLK_W-1:0] ext_len;
    logic             last;
  } ext_item_t;

  // Number of extents waiting in the output buffer.
  typedef logic [1:0] count_t;

endpackage

// ===== hdl/brec_if.sv =====
// ----------------------------------------------------------------------------
// brec channel interfaces
// Valid/ready channels for mapping words, extent words and register writes.
// ----------------------------------------------------------------------------
interface brec_in_if;
  import brec_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brec_out_if;
  import brec_pkg::*;
  logic      valid;
  logic      ready;
  ext_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brec_cfg_if;
  import brec_pkg::*;
  logic               valid;
  logic               ready;
  logic [SHIFT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/block_run_extent_coalescer.sv =====
// ----------------------------------------------------------------------------
// block_run_extent_coalescer
// Merges a stream of file-block to disk-sector mappings into extents,
// emitting finished runs and holes for skipped file blocks.
// ----------------------------------------------------------------------------
//
//   channel   direction  word                     handshake
//   in_word   in         one block mapping        valid/ready
//   out_word  out        one extent, last marked  valid/ready
//   cfg_word  in         sector shift register    valid/ready, always ready
//
// A mapping word is taken in every cycle while the extent words of the
// previous mapping have gone or are going in that cycle; a mapping that
// yields two extents therefore holds the input until the first has gone.
// The extents a mapping finishes appear on out_word in the cycle after it is taken.
// The throughput limit is the single output port: one extent word per cycle unless out_word stalls.
// Reset (rst_n low, synchronous) empties the output buffer, clears the run
// and removes the barrier; the sector shift returns to 12.
// A stall on out_word holds the buffered words and, once the buffer cannot
// take a further mapping, holds in_word.ready low.
// ----------------------------------------------------------------------------
module block_run_extent_coalescer (
  input  logic       clk,
  input  logic       rst_n,
  brec_in_if.sink    in_word,
  brec_out_if.source out_word,
  brec_cfg_if.sink   cfg_word
);
  import brec_pkg::*;

  // Run state. The barrier sector of all ones means that no barrier is set.
  logic [BLK_W-1:0]   run_file_start_r, run_file_start_nxt;
  logic [BLK_W-1:0]   run_disk_start_r, run_disk_start_nxt;
  logic [BLK_W-1:0]   run_length_r, run_length_nxt;
  logic [BLK_W-1:0]   barrier_block_r, barrier_block_nxt;
  logic [SHIFT_W-1:0] sector_shift_r;

  // Output buffer: ext0_r is the word on the port, ext1_r waits behind it.
  ext_item_t ext0_r, ext0_nxt;
  ext_item_t ext1_r, ext1_nxt;
  count_t    cnt_r, cnt_nxt;

  logic in_fire;
  logic out_fire;

  // Per-item evaluation signals.
  logic [SHIFT_W-1:0]  sh;
  logic [BYTE_W-1:0]   byte_pos;
  logic [BYTE_W:0]     byte_end;
  logic                touch0, touch1, touch2;
  logic                touch_any;
  logic [BYTE_W-1:0]   res_end;
  logic                past_barrier;
  logic                brk;
  logic [BLK_W:0]      run_file_end;
  logic [BLK_W:0]      run_disk_end;
  logic [BLK_W-1:0]    hole_start;
  logic                emit_run;
  logic                emit_hole;
  logic [BYTE_W-1:0]   nb_bytes;
  logic [BYTE_W-1:0]   nb_sectors;
  ext_item_t           run_ext;
  ext_item_t           hole_ext;
  count_t              n_res;

  // The buffer must be empty after this cycle's pop before a mapping enters,
  // since one mapping may leave two extents behind.
  assign in_word.ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_word.ready);
  assign in_fire        = in_word.valid && in_word.ready;
  assign out_word.valid = (cnt_r != 2'd0);
  assign out_word.data  = ext0_r;
  assign out_fire       = out_word.valid && out_word.ready;
  assign cfg_word.ready = 1'b1;

  // Out-of-range shift values are clamped to the supported sector sizes.
  always_comb begin
    if (sector_shift_r < SHIFT_MIN) begin
      sh = SHIFT_MIN;
    end else if (sector_shift_r > SHIFT_MAX) begin
      sh = SHIFT_MAX;
    end else begin
      sh = sector_shift_r;
    end
  end

  always_comb begin
    // A 48-bit sector shifted by at most 16 fits the 64-bit byte address.
    byte_pos = {{(BYTE_W-BLK_W){1'b0}}, in_word.data.disk_blk} << sh;
    byte_end = {1'b0, byte_pos} + ({{BYTE_W{1'b0}}, 1'b1} << sh);

    // A sector touches a range if it starts below the range end and its
    // byte end reaches the range start; a sector ending on the start counts.
    touch0    = (byte_pos < RES0_END);
    touch1    = (byte_pos < RES1_END) && (byte_end >= {1'b0, RES1_START});
    touch2    = (byte_pos < RES2_END) && (byte_end >= {1'b0, RES2_START});
    touch_any = touch0 || touch1 || touch2;

    if (touch0) begin
      res_end = RES0_END;
    end else if (touch1) begin
      res_end = RES1_END;
    end else begin
      res_end = RES2_END;
    end

    past_barrier = (barrier_block_r != BLK_ONES) &&
                   (in_word.data.disk_blk >= barrier_block_r);

    // Run ends are compared with one extra bit so that they never wrap.
    run_file_end = {1'b0, run_file_start_r} + {1'b0, run_length_r};
    run_disk_end = {1'b0, run_disk_start_r} + {1'b0, run_length_r};

    emit_run = (run_length_r != '0);
    brk = (emit_run && (touch_any || past_barrier)) ||
          ({1'b0, in_word.data.file_blk} > run_file_end) ||
          ({1'b0, in_word.data.disk_blk} != run_disk_end);

    // The hole starts where the finished run stops, or at the run start of
    // an empty run. A file block behind that point makes no hole.
    hole_start = emit_run ? run_file_end[BLK_W-1:0] : run_file_start_r;
    emit_hole  = (in_word.data.file_blk > hole_start);

    run_ext.ext_file_blk  = run_file_start_r;
    run_ext.ext_disk_blk  = run_disk_start_r;
    run_ext.ext_len       = run_length_r;
    run_ext.last          = !emit_hole;
    hole_ext.ext_file_blk = hole_start;
    hole_ext.ext_disk_blk = '0;
    hole_ext.ext_len      = in_word.data.file_blk - hole_start;
    hole_ext.last         = 1'b1;

    // New barrier in sectors, saturated to the no-barrier value.
    nb_bytes   = touch_any ? res_end : in_word.data.group_end_byte;
    nb_sectors = nb_bytes >> sh;

    if (brk) begin
      n_res = count_t'({1'b0, emit_run} + {1'b0, emit_hole});
    end else begin
      n_res = 2'd0;
    end
  end

  always_comb begin
    run_file_start_nxt = run_file_start_r;
    run_disk_start_nxt = run_disk_start_r;
    run_length_nxt     = run_length_r;
    barrier_block_nxt  = barrier_block_r;
    ext0_nxt           = ext0_r;
    ext1_nxt           = ext1_r;
    cnt_nxt            = cnt_r;

    if (in_fire) begin
      if (brk) begin
        run_file_start_nxt = in_word.data.file_blk;
        run_disk_start_nxt = in_word.data.disk_blk;
        run_length_nxt     = {{(BLK_W-1){1'b0}}, 1'b1};
        if (nb_sectors[BYTE_W-1:BLK_W] != '0) begin
          barrier_block_nxt = BLK_ONES;
        end else begin
          barrier_block_nxt = nb_sectors[BLK_W-1:0];
        end
      end else begin
        run_length_nxt = run_length_r + {{(BLK_W-1){1'b0}}, 1'b1};
      end
      // Any word still buffered leaves in this very cycle.
      ext0_nxt = emit_run ? run_ext : hole_ext;
      ext1_nxt = hole_ext;
      cnt_nxt  = n_res;
    end else if (out_fire) begin
      ext0_nxt = ext1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_file_start_r <= '0;
      run_disk_start_r <= '0;
      run_length_r     <= '0;
      barrier_block_r  <= BLK_ONES;
      sector_shift_r   <= SHIFT_MIN;
      cnt_r            <= '0;
    end else begin
      run_file_start_r <= run_file_start_nxt;
      run_disk_start_r <= run_disk_start_nxt;
      run_length_r     <= run_length_nxt;
      barrier_block_r  <= barrier_block_nxt;
      cnt_r            <= cnt_nxt;
      if (cfg_word.valid && cfg_word.ready) begin
        sector_shift_r <= cfg_word.data;
      end
    end
  end

  // Extent words carry no reset; the count says which of them are live.
  always_ff @(posedge clk) begin
    ext0_r <= ext0_nxt;
    ext1_r <= ext1_nxt;
  end

`include "block_run_extent_coalescer_assert.svh"

  // A mapping is never taken while two extents are still waiting.
  `BREC_ASSERT_NOW(a_no_overrun, in_fire, cnt_r != 2'd2, "mapping taken into a full buffer")
  // After any accepted mapping the current run holds at least that block.
  `BREC_ASSERT_NEXT(a_run_nonempty, in_fire, run_length_r != '0, "run empty after a mapping")
  // The front word of a pair is never marked as the last one.
  `BREC_ASSERT_NOW(a_pair_last, cnt_r == 2'd2, !ext0_r.last, "first word of a pair marked last")
  // Without traffic on either side the buffer fill does not change.
  `BREC_ASSERT_NEXT(a_cnt_hold, !in_fire && !out_fire, $stable(cnt_r), "buffer fill changed idle")

endmodule
